>>> sv/tkins_pkg.sv
// shared types and constants for the top-k sorted insertion table
package tkins_pkg;

  localparam int RANK_W    = 4;
  localparam int RANK_SPAN = 16;
  localparam int TOTAL_W   = 5;
  localparam int SCORE_W   = 32;
  localparam int BOARD_W   = 32;
  localparam int COLORS_W  = 4;
  localparam int NAME_W    = 64;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic signed [BOARD_W-1:0] board;
    logic [COLORS_W-1:0]       colors;
    logic [NAME_W-1:0]         name_low;
    logic [NAME_W-1:0]         name_high;
  } entry_t;

  // status one cell hands to the cell below it
  typedef struct packed {
    logic valid;
    logic keep;
  } link_t;

  // per-cell status gathered by the top level
  typedef struct packed {
    logic hit;
    logic take;
  } cell_stat_t;

endpackage

>>> sv/tkins_cell.sv
// one rank of the sorted table: holds an entry, compares and shifts down
module tkins_cell import tkins_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ins,
  input  entry_t            new_entry,
  input  logic [RANK_W-1:0] rank,
  input  link_t             prev,
  input  entry_t            prev_entry,
  output link_t             link,
  output entry_t            entry,
  output entry_t            rd_entry,
  output logic [RANK_W-1:0] pos_code,
  output cell_stat_t        stat
);

  localparam int RankMod = IDX % RANK_SPAN;
  localparam logic [RANK_W-1:0] IdxCode = RankMod[RANK_W-1:0];
  localparam logic InSpan = (IDX < RANK_SPAN);

  logic valid;
  logic keep;
  logic take_new;

  // entries at or above the new score stay put
  assign keep     = valid && ($signed(new_entry.score) <= $signed(entry.score));
  assign take_new = !keep && prev.keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins && !keep) begin
      valid <= take_new | prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins && !keep) begin
      entry <= take_new ? new_entry : prev_entry;
    end
  end

  assign link     = '{valid: valid, keep: keep};
  assign stat.take = take_new;
  assign stat.hit  = valid && InSpan && (rank == IdxCode);
  assign pos_code = take_new ? IdxCode : '0;
  assign rd_entry = stat.hit ? entry : '0;

endmodule

>>> sv/top_k_sorted_insert_core.sv
// top level of the top-k sorted insertion table: cell chain and result register
// an accepted item's result is in the output register in the cycle after acceptance
// throughput: one item per cycle while the output is not stalled, set by a single compare-and-shift step in every cell
// the output register frees up whenever the result is taken, so items flow back to back
// reset: synchronous, clears all cell valid bits, the entry count and the output valid
module top_k_sorted_insert_core import tkins_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [RANK_W-1:0]          rank_index,
  input  logic signed [SCORE_W-1:0]  new_score,
  input  logic signed [BOARD_W-1:0]  new_board,
  input  logic [COLORS_W-1:0]        new_colors,
  input  logic [NAME_W-1:0]          new_name_low,
  input  logic [NAME_W-1:0]          new_name_high,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       placed,
  output logic [RANK_W-1:0]          placed_rank,
  output logic [TOTAL_W-1:0]         entry_total,
  output logic signed [SCORE_W-1:0]  out_score,
  output logic signed [BOARD_W-1:0]  out_board,
  output logic [COLORS_W-1:0]        out_colors,
  output logic [NAME_W-1:0]          out_name_low,
  output logic [NAME_W-1:0]          out_name_high
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  // handshake: the output register refills whenever it is empty or being taken
  logic accept;
  logic is_read;
  logic ins;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_read  = (cmd_t'(cmd) == CMD_READ);
  assign ins      = accept && !is_read;

  entry_t new_entry;
  assign new_entry = '{score: new_score, board: new_board, colors: new_colors,
                       name_low: new_name_low, name_high: new_name_high};

  // cell chain, rank 0 on top; cell 0 sees an always-keeping neighbor above
  link_t             links   [DEPTH];
  entry_t            ents    [DEPTH];
  entry_t            rd_ents [DEPTH];
  logic [RANK_W-1:0] pos     [DEPTH];
  cell_stat_t        stats   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t  up_link;
    entry_t up_entry;
    if (i == 0) begin : g_head
      assign up_link  = '{valid: 1'b0, keep: 1'b1};
      assign up_entry = new_entry;
    end else begin : g_body
      assign up_link  = links[i-1];
      assign up_entry = ents[i-1];
    end
    tkins_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ins        (ins),
      .new_entry  (new_entry),
      .rank       (rank_index),
      .prev       (up_link),
      .prev_entry (up_entry),
      .link       (links[i]),
      .entry      (ents[i]),
      .rd_entry   (rd_ents[i]),
      .pos_code   (pos[i]),
      .stat       (stats[i])
    );
  end

  // gather: at most one cell takes the new entry, at most one matches the rank
  logic              any_take;
  logic              any_hit;
  logic [RANK_W-1:0] take_rank;
  entry_t            rd_sel;

  always_comb begin
    any_take  = 1'b0;
    any_hit   = 1'b0;
    take_rank = '0;
    rd_sel    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_take  = any_take | stats[i].take;
      any_hit   = any_hit | stats[i].hit;
      take_rank = take_rank | pos[i];
      rd_sel    = rd_sel | rd_ents[i];
    end
  end

  // entry count saturates at the table depth
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (ins && any_take && (count < CntFull)) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_total <= TOTAL_W'(count_next);
      if (is_read) begin
        // read: entry at the rank, or zeros past the count
        placed        <= any_hit;
        placed_rank   <= '0;
        out_score     <= rd_sel.score;
        out_board     <= rd_sel.board;
        out_colors    <= rd_sel.colors;
        out_name_low  <= rd_sel.name_low;
        out_name_high <= rd_sel.name_high;
      end else begin
        // insert: report where the item landed, payload fields read as zero
        placed        <= any_take;
        placed_rank   <= take_rank;
        out_score     <= '0;
        out_board     <= '0;
        out_colors    <= '0;
        out_name_low  <= '0;
        out_name_high <= '0;
      end
    end
  end

endmodule

>>> sim/top_k_sorted_insert_core_tb.sv
// self-checking testbench for the top-k sorted insertion table core
module top_k_sorted_insert_core_tb;
  import tkins_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES  = 4;
  localparam int MAX_SHOWN    = 10;

  // one input item as the sender sees it
  typedef struct packed {
    cmd_t                      cmd;
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] score;
    logic signed [BOARD_W-1:0] board;
    logic [COLORS_W-1:0]       colors;
    logic [NAME_W-1:0]         name_low;
    logic [NAME_W-1:0]         name_high;
  } item_t;

  // one result item, laid out like the output ports
  typedef struct packed {
    logic                      placed;
    logic [RANK_W-1:0]         placed_rank;
    logic [TOTAL_W-1:0]        entry_total;
    logic signed [SCORE_W-1:0] score;
    logic signed [BOARD_W-1:0] board;
    logic [COLORS_W-1:0]       colors;
    logic [NAME_W-1:0]         name_low;
    logic [NAME_W-1:0]         name_high;
  } result_t;

  // a row of the directed table: typed rows carry their own expectation
  typedef struct packed {
    item_t   item;
    logic    typed;
    result_t want;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      cmd = 1'b0;
  logic [RANK_W-1:0]         rank_index = '0;
  logic signed [SCORE_W-1:0] new_score = '0;
  logic signed [BOARD_W-1:0] new_board = '0;
  logic [COLORS_W-1:0]       new_colors = '0;
  logic [NAME_W-1:0]         new_name_low = '0;
  logic [NAME_W-1:0]         new_name_high = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      placed;
  logic [RANK_W-1:0]         placed_rank;
  logic [TOTAL_W-1:0]        entry_total;
  logic signed [SCORE_W-1:0] out_score;
  logic signed [BOARD_W-1:0] out_board;
  logic [COLORS_W-1:0]       out_colors;
  logic [NAME_W-1:0]         out_name_low;
  logic [NAME_W-1:0]         out_name_high;

  // predictor state: the ranked table and its fill level
  entry_t  ranked [RANK_SPAN];
  int      ranked_count = 0;

  // results still owed by the block, oldest first
  result_t due_results [$];
  row_t    directed_rows [$];

  int      fails = 0;
  // high while neither side may idle
  logic    calm = 1'b0;

  top_k_sorted_insert_core #(
    .DEPTH(RANK_SPAN)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .rank_index   (rank_index),
    .new_score    (new_score),
    .new_board    (new_board),
    .new_colors   (new_colors),
    .new_name_low (new_name_low),
    .new_name_high(new_name_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .placed       (placed),
    .placed_rank  (placed_rank),
    .entry_total  (entry_total),
    .out_score    (out_score),
    .out_board    (out_board),
    .out_colors   (out_colors),
    .out_name_low (out_name_low),
    .out_name_high(out_name_high)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // insert walks up from the bottom, shifting strictly lower scores down;
  // ties keep the older entry above, a full table drops its last entry
  function automatic result_t rank_table_step(input item_t it);
    result_t r;
    int      slot;
    r = '0;
    if (it.cmd == CMD_READ) begin
      if (int'(it.rank) < ranked_count) begin
        r.placed    = 1'b1;
        r.score     = ranked[it.rank].score;
        r.board     = ranked[it.rank].board;
        r.colors    = ranked[it.rank].colors;
        r.name_low  = ranked[it.rank].name_low;
        r.name_high = ranked[it.rank].name_high;
      end
    end else begin
      slot = ranked_count;
      while (slot > 0 && it.score > ranked[slot-1].score) begin
        if (slot < RANK_SPAN) ranked[slot] = ranked[slot-1];
        slot--;
      end
      // slot at the depth means the table is full and the score too low
      if (slot < RANK_SPAN) begin
        ranked[slot].score     = it.score;
        ranked[slot].board     = it.board;
        ranked[slot].colors    = it.colors;
        ranked[slot].name_low  = it.name_low;
        ranked[slot].name_high = it.name_high;
        if (ranked_count < RANK_SPAN) ranked_count++;
        r.placed      = 1'b1;
        r.placed_rank = slot[RANK_W-1:0];
      end
    end
    r.entry_total = ranked_count[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic item_t mk_insert(input logic signed [SCORE_W-1:0] score,
                                      input logic signed [BOARD_W-1:0] board,
                                      input logic [COLORS_W-1:0] colors,
                                      input logic [NAME_W-1:0] name_low,
                                      input logic [NAME_W-1:0] name_high);
    item_t it;
    it           = '0;
    it.cmd       = CMD_INSERT;
    it.score     = score;
    it.board     = board;
    it.colors    = colors;
    it.name_low  = name_low;
    it.name_high = name_high;
    return it;
  endfunction

  function automatic item_t mk_read(input logic [RANK_W-1:0] rank);
    item_t it;
    it      = '0;
    it.cmd  = CMD_READ;
    it.rank = rank;
    return it;
  endfunction

  // expectation with all payload outputs at zero
  function automatic result_t known_result(input logic p, input logic [RANK_W-1:0] rank,
                                           input logic [TOTAL_W-1:0] total);
    result_t r;
    r             = '0;
    r.placed      = p;
    r.placed_rank = rank;
    r.entry_total = total;
    return r;
  endfunction

  task automatic add_row(input item_t it, input logic typed, input result_t want);
    row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  function automatic string fmt_result(input result_t r);
    return $sformatf("placed=%0d rank=%0d total=%0d score=%h board=%h colors=%h name=%h_%h",
                     r.placed, r.placed_rank, r.entry_total, r.score, r.board, r.colors,
                     r.name_high, r.name_low);
  endfunction

  // random item: reads at any rank, inserts biased toward ties and the cut-off
  function automatic item_t random_item();
    item_t it;
    int    pick;
    it           = '0;
    it.cmd       = ($urandom_range(99) < 40) ? CMD_READ : CMD_INSERT;
    it.rank      = RANK_W'($urandom_range(RANK_SPAN-1));
    it.board     = $urandom;
    it.colors    = COLORS_W'($urandom_range(15));
    it.name_low  = {$urandom, $urandom};
    it.name_high = {$urandom, $urandom};
    case ($urandom_range(3))
      0: begin
        // small range, many equal scores
        it.score = $urandom_range(8);
        it.score = it.score - 4;
      end
      1: it.score = $urandom;
      2: begin
        pick = $urandom_range(5);
        case (pick)
          0: it.score = SCORE_MIN;
          1: it.score = SCORE_MIN + 1;
          2: it.score = SCORE_MAX;
          3: it.score = SCORE_MAX - 1;
          4: it.score = '0;
          default: it.score = -1;
        endcase
      end
      default: begin
        // right around the current last entry
        if (ranked_count > 0) begin
          it.score = ranked[ranked_count-1].score;
          it.score = it.score + $signed($urandom_range(2)) - 1;
        end else begin
          it.score = $urandom;
        end
      end
    endcase
    return it;
  endfunction

  // present one item and hold it until the handshake; predict at acceptance
  task automatic drive_item(input item_t it, input logic typed, input result_t want);
    result_t r;
    in_valid      <= 1'b1;
    cmd           <= it.cmd;
    rank_index    <= it.rank;
    new_score     <= it.score;
    new_board     <= it.board;
    new_colors    <= it.colors;
    new_name_low  <= it.name_low;
    new_name_high <= it.name_high;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = rank_table_step(it);
    due_results.push_back(typed ? want : r);
  endtask

  // sender gap after an accepted item, entered about one time in five outside the calm stretch
  task automatic sender_gap();
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 20) @(posedge clk);
    end
  endtask

  // receiver stalls at random except in the calm stretch
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
  end

  // result checker: every taken result against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.placed      = placed;
      got.placed_rank = placed_rank;
      got.entry_total = entry_total;
      got.score       = out_score;
      got.board       = out_board;
      got.colors      = out_colors;
      got.name_low    = out_name_low;
      got.name_high   = out_name_high;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN) $display("unexpected result: %s", fmt_result(got));
      end else begin
        want = due_results.pop_front();
        if (got.placed !== want.placed || got.placed_rank !== want.placed_rank ||
            got.entry_total !== want.entry_total || got.score !== want.score ||
            got.board !== want.board || got.colors !== want.colors ||
            got.name_low !== want.name_low || got.name_high !== want.name_high) begin
          fails++;
          if (fails <= MAX_SHOWN) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  // main sequence: reset, directed table, random items, drain
  initial begin
    item_t it;
    // after reset: reads see an empty table
    add_row(mk_read(0), 1'b1, known_result(1'b0, 0, 0));
    add_row(mk_read(RANK_W'(RANK_SPAN-1)), 1'b1, known_result(1'b0, 0, 0));
    // first insert lands at the top, all-ones payload
    add_row(mk_insert('0, -1, '1, '1, '1), 1'b1, known_result(1'b1, 0, 1));
    add_row(mk_read(0), 1'b0, '0);
    // highest score goes above everything
    add_row(mk_insert(SCORE_MAX, '0, '0, '0, '0), 1'b1, known_result(1'b1, 0, 2));
    // lowest score goes to the bottom
    add_row(mk_insert(SCORE_MIN, 32'sh5a5a_a5a5, 4'h5, 64'h0123_4567_89ab_cdef,
                      64'hfedc_ba98_7654_3210), 1'b1, known_result(1'b1, 2, 3));
    // equal score sits below the older entry with the same score
    add_row(mk_insert('0, 32'sh0000_0007, 4'ha, 64'h2020_2020_2020_6f6f,
                      64'h0000_0000_2020_2020), 1'b1, known_result(1'b1, 2, 4));
    add_row(mk_read(2), 1'b0, '0);
    // read past the fill level of a non-empty table
    add_row(mk_read(RANK_W'(RANK_SPAN-2)), 1'b0, '0);
    // fill up with ties at the lowest score
    for (int k = 0; k < RANK_SPAN-4; k++) begin
      add_row(mk_insert(SCORE_MIN, 32'sh1000_0000 + k, k[COLORS_W-1:0],
                        {$urandom, $urandom}, {$urandom, $urandom}), 1'b0, '0);
    end
    // full table, score not above the last: rejected
    add_row(mk_insert(SCORE_MIN, -1, '1, '1, '1), 1'b1,
            known_result(1'b0, 0, TOTAL_W'(RANK_SPAN)));
    // full table, one above the last: lands above the lowest scores, the bottom entry drops
    add_row(mk_insert(SCORE_MIN + 1, 32'sh7777_7777, 4'h3, '0, '1), 1'b0, '0);
    add_row(mk_read(RANK_W'(RANK_SPAN-1)), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // stretch with no idling on either side
      calm = (n >= 150 && n < 250);
      it = random_item();
      drive_item(it, 1'b0, '0);
      if (n == 400) begin
        // hold off until the block has handed back everything
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end
    calm = 1'b0;

    // drain, then wait out the tail for any stray result
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) fails++;

    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
